/* sv/bsr_pkg.sv */
`timescale 1ns / 1ps

package bsr_pkg;

	// command codes
	typedef enum logic [2:0] {
		CMD_CLEAR     = 3'd0,
		CMD_ADD       = 3'd1,
		CMD_REMOVE    = 3'd2,
		CMD_TEST      = 3'd3,
		CMD_UNION     = 3'd4,
		CMD_INTERSECT = 3'd5,
		CMD_DIFF      = 3'd6,
		CMD_READ      = 3'd7
	} cmd_t;

	localparam int SET_IDX_W = 3;
	localparam int ELEM_W    = 7;
	localparam int DATA_W    = 64;

	// request payload
	typedef struct packed {
		cmd_t                 cmd;
		logic [SET_IDX_W-1:0] dst_set;
		logic [SET_IDX_W-1:0] src_a_set;
		logic [SET_IDX_W-1:0] src_b_set;
		logic [ELEM_W-1:0]    element;
		logic                 word_index;
	} req_t;

	// result payload
	typedef struct packed {
		logic              is_member;
		logic [DATA_W-1:0] data_word;
		logic              set_empty;
		logic              error;
	} rsp_t;

endpackage

/* sv/bsr_req_if.sv */
`timescale 1ns / 1ps

interface bsr_req_if;
	logic          valid;
	logic          ready;
	bsr_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/bsr_rsp_if.sv */
`timescale 1ns / 1ps

interface bsr_rsp_if;
	logic          valid;
	logic          ready;
	bsr_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/bitset_register_file_ops_top.sv */
`timescale 1ns / 1ps
// channel   modport  payload  direction
// request   sink     req_t    command into the set file
// result    source   rsp_t    one result per command
//
// The set memory is read at the accept edge, and the modify stage then modifies the set,
// writes it back and registers the result. The next request is taken only after the
// write back, so a new request is not taken while the last one is in the modify stage.
// Reset clears one valid flag per set, so every set reads empty with no clearing pass.
// A result held in the output register does not block the next request; a second
// finished result waits in the modify stage until the output register frees.

module bitset_register_file_ops_top #(
	parameter int SET_BITS = 128,
	parameter int NUM_SETS = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	bsr_req_if.sink   request,
	bsr_rsp_if.source result
);
	import bsr_pkg::*;

	localparam int ADDR_W = $clog2(NUM_SETS);

	logic                busy_q;
	logic                out_valid_q;
	rsp_t                rsp_q;
	logic [NUM_SETS-1:0] valid_q;

	req_t                req_s1;
	logic                ok_s1;
	logic                valid_a_s1;
	logic                valid_b_s1;

	logic                accept;
	logic                load;
	logic                is_op;
	logic                ok;
	logic [ADDR_W-1:0]   addr_a;
	logic [ADDR_W-1:0]   addr_b;
	logic [ADDR_W-1:0]   waddr;
	logic [SET_BITS-1:0] raw_a;
	logic [SET_BITS-1:0] raw_b;
	logic [SET_BITS-1:0] rd_a;
	logic [SET_BITS-1:0] rd_b;
	rsp_t                rsp;
	logic                wr_en;
	logic [SET_BITS-1:0] wr_data;

	assign request.ready = ~busy_q;
	assign accept        = request.valid & ~busy_q;
	assign load          = busy_q & (~out_valid_q | result.ready);

	// index checks and read addresses
	always_comb begin
		is_op  = request.data.cmd inside {CMD_UNION, CMD_INTERSECT, CMD_DIFF};
		ok     = int'(request.data.dst_set) < NUM_SETS;
		if (is_op) begin
			ok = ok && (int'(request.data.src_a_set) < NUM_SETS)
			        && (int'(request.data.src_b_set) < NUM_SETS);
		end
		addr_a = ADDR_W'(is_op ? request.data.src_a_set : request.data.dst_set);
		addr_b = ADDR_W'(request.data.src_b_set);
	end

	// capture the request while the memory is read
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1     <= request.data;
			ok_s1      <= ok;
			valid_a_s1 <= ok & valid_q[addr_a];
			valid_b_s1 <= ok & valid_q[addr_b];
		end
	end

	bsr_ram #(
		.WIDTH (SET_BITS),
		.DEPTH (NUM_SETS)
	) u_ram (
		.clk     (clk),
		.we      (load & wr_en),
		.waddr   (waddr),
		.wdata   (wr_data),
		.re      (accept),
		.raddr_a (addr_a),
		.raddr_b (addr_b),
		.rdata_a (raw_a),
		.rdata_b (raw_b)
	);

	// never-written sets read as empty
	assign rd_a  = valid_a_s1 ? raw_a : '0;
	assign rd_b  = valid_b_s1 ? raw_b : '0;
	assign waddr = ADDR_W'(req_s1.dst_set);

	bsr_alu #(
		.SET_BITS (SET_BITS)
	) u_alu (
		.req     (req_s1),
		.ok      (ok_s1),
		.rd_a    (rd_a),
		.rd_b    (rd_b),
		.rsp     (rsp),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	// control: busy flag, output valid, per-set valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load && wr_en) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = rsp_q;

endmodule

/* sv/bsr_ram.sv */
`timescale 1ns / 1ps

module bsr_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* sv/bsr_alu.sv */
`timescale 1ns / 1ps

module bsr_alu #(
	parameter int SET_BITS = 128
) (
	input  bsr_pkg::req_t        req,
	input  logic                 ok,
	input  logic [SET_BITS-1:0]  rd_a,
	input  logic [SET_BITS-1:0]  rd_b,
	output bsr_pkg::rsp_t        rsp,
	output logic                 wr_en,
	output logic [SET_BITS-1:0]  wr_data
);
	import bsr_pkg::*;

	localparam int IDX_W     = $clog2(SET_BITS);
	localparam int WORDS     = (SET_BITS + 63) / 64;
	localparam int PAD_WORDS = (WORDS < 2) ? 2 : WORDS;
	localparam int PAD_W     = PAD_WORDS * 64;

	logic                elem_ok;
	logic [SET_BITS-1:0] bit_mask;
	logic [SET_BITS-1:0] new_set;
	logic [PAD_W-1:0]    padded;
	logic [DATA_W-1:0]   word;
	logic                member;
	logic                wr;

	// single-element mask, empty when the element lies past the set
	always_comb begin
		elem_ok  = int'(req.element) < SET_BITS;
		bit_mask = '0;
		if (elem_ok) begin
			bit_mask[IDX_W'(req.element)] = 1'b1;
		end
	end

	assign padded = PAD_W'(rd_a);

	// read-modify of the addressed set
	always_comb begin
		new_set = rd_a;
		member  = 1'b0;
		word    = '0;
		wr      = 1'b0;
		unique case (req.cmd)
			CMD_CLEAR: begin
				new_set = '0;
				wr      = 1'b1;
			end
			CMD_ADD: begin
				new_set = rd_a | bit_mask;
				wr      = 1'b1;
			end
			CMD_REMOVE: begin
				new_set = rd_a & ~bit_mask;
				wr      = 1'b1;
			end
			CMD_TEST: begin
				member = |(rd_a & bit_mask);
			end
			CMD_UNION: begin
				new_set = rd_a | rd_b;
				wr      = 1'b1;
			end
			CMD_INTERSECT: begin
				new_set = rd_a & rd_b;
				wr      = 1'b1;
			end
			CMD_DIFF: begin
				new_set = rd_a & ~rd_b;
				wr      = 1'b1;
			end
			CMD_READ: begin
				if (!req.word_index) begin
					word = padded[63:0];
				end else if (WORDS > 1) begin
					word = padded[127:64];
				end
			end
		endcase
	end

	// bad set index zeroes every field but the error flag
	always_comb begin
		rsp.is_member = ok & member;
		rsp.data_word = ok ? word : '0;
		rsp.set_empty = ok & ~(|new_set);
		rsp.error     = ~ok;
	end

	assign wr_en   = ok & wr;
	assign wr_data = new_set;

endmodule

/* sv/bsr_checker.sv */
`timescale 1ns / 1ps

module bsr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input bsr_pkg::rsp_t rsp_data
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// a taken request blocks the next one until its write back
	a_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken during write back");

	// an error result carries no other information
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.error |->
			!rsp_data.is_member && (rsp_data.data_word == 64'd0) && !rsp_data.set_empty)
		else $error("error result with nonzero fields");

	// a nonzero word read comes from a nonempty set, never from a test
	a_word_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.data_word != 64'd0) |->
			!rsp_data.set_empty && !rsp_data.is_member && !rsp_data.error)
		else $error("nonzero word with empty set or member flag");

endmodule

bind bitset_register_file_ops_top bsr_checker u_bsr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.rsp_valid (result.valid),
	.rsp_ready (result.ready),
	.rsp_data  (result.data)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import bsr_pkg::*;

	localparam int SET_BITS   = 128;
	localparam int NUM_SETS   = 6;
	localparam int WORDS      = (SET_BITS + 63) / 64;
	localparam int STALL_MAX  = 4000;
	localparam int HOLD_LEN   = 300;

	logic clk;
	logic arst_n;

	bsr_req_if req_ch();
	bsr_rsp_if rsp_ch();

	bitset_register_file_ops_top #(
		.SET_BITS(SET_BITS),
		.NUM_SETS(NUM_SETS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_ch),
		.result(rsp_ch)
	);

	// mirror of the set file and the results it predicts
	logic [SET_BITS-1:0] set_mirror [NUM_SETS];
	rsp_t                rsp_due_q [$];

	int fail_cnt     = 0;
	int src_idle_pct = 0;
	int dst_idle_pct = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one command to the mirror and return the result it should give
	function automatic rsp_t apply_set_cmd(input req_t r);
		rsp_t                o;
		logic                ok;
		logic [SET_BITS-1:0] a;
		logic [SET_BITS-1:0] b;
		o  = '0;
		ok = (r.dst_set < NUM_SETS);
		if (r.cmd inside {CMD_UNION, CMD_INTERSECT, CMD_DIFF})
			ok = ok && (r.src_a_set < NUM_SETS) && (r.src_b_set < NUM_SETS);
		if (!ok) begin
			o.error = 1'b1;
			return o;
		end
		case (r.cmd)
			CMD_CLEAR: begin
				set_mirror[r.dst_set] = '0;
			end
			CMD_ADD: begin
				if (r.element < SET_BITS)
					set_mirror[r.dst_set][r.element] = 1'b1;
			end
			CMD_REMOVE: begin
				if (r.element < SET_BITS)
					set_mirror[r.dst_set][r.element] = 1'b0;
			end
			CMD_TEST: begin
				if (r.element < SET_BITS)
					o.is_member = set_mirror[r.dst_set][r.element];
			end
			CMD_UNION, CMD_INTERSECT, CMD_DIFF: begin
				// operands taken before the write, so aliasing is safe
				a = set_mirror[r.src_a_set];
				b = set_mirror[r.src_b_set];
				if (r.cmd == CMD_UNION)
					set_mirror[r.dst_set] = a | b;
				else if (r.cmd == CMD_INTERSECT)
					set_mirror[r.dst_set] = a & b;
				else
					set_mirror[r.dst_set] = a & ~b;
			end
			default: begin
				if (r.word_index < WORDS)
					o.data_word = set_mirror[r.dst_set][r.word_index * DATA_W +: DATA_W];
			end
		endcase
		o.set_empty = (set_mirror[r.dst_set] == '0);
		return o;
	endfunction

	function automatic req_t mk_req(input cmd_t c, input int dst, input int a, input int b,
			input int elem, input int widx);
		req_t r;
		r.cmd        = c;
		r.dst_set    = dst[SET_IDX_W-1:0];
		r.src_a_set  = a[SET_IDX_W-1:0];
		r.src_b_set  = b[SET_IDX_W-1:0];
		r.element    = elem[ELEM_W-1:0];
		r.word_index = widx[0];
		return r;
	endfunction

	// send one request; returns at the falling edge after it is taken
	task automatic send_req(input req_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do
			@(posedge clk);
		while (!req_ch.ready);
		rsp_due_q.push_back(apply_set_cmd(r));
		@(negedge clk);
	endtask

	// stop offering and wait until every expected result is back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (rsp_due_q.size() != 0)
			@(negedge clk);
	endtask

	// clear, add, remove, test and read of elements on one set
	task automatic test_membership();
		send_req(mk_req(CMD_CLEAR, 0, 0, 0, 0, 0));
		send_req(mk_req(CMD_ADD, 0, 0, 0, 0, 0));
		send_req(mk_req(CMD_ADD, 0, 0, 0, 127, 0));
		send_req(mk_req(CMD_ADD, 0, 0, 0, 64, 0));
		send_req(mk_req(CMD_TEST, 0, 0, 0, 0, 0));
		send_req(mk_req(CMD_TEST, 0, 0, 0, 127, 0));
		send_req(mk_req(CMD_TEST, 0, 0, 0, 63, 0));
		send_req(mk_req(CMD_READ, 0, 0, 0, 0, 0));
		send_req(mk_req(CMD_READ, 0, 0, 0, 0, 1));
		send_req(mk_req(CMD_REMOVE, 0, 0, 0, 127, 0));
		send_req(mk_req(CMD_TEST, 0, 0, 0, 127, 0));
		send_req(mk_req(CMD_READ, 0, 0, 0, 0, 1));
	endtask

	// union, intersection, difference, with aliased operands
	task automatic test_set_algebra();
		send_req(mk_req(CMD_ADD, 1, 0, 0, 63, 0));
		send_req(mk_req(CMD_ADD, 1, 0, 0, 0, 0));
		send_req(mk_req(CMD_UNION, 2, 0, 1, 0, 0));
		send_req(mk_req(CMD_INTERSECT, 3, 0, 1, 0, 0));
		send_req(mk_req(CMD_DIFF, 4, 0, 1, 0, 0));
		send_req(mk_req(CMD_DIFF, 0, 0, 0, 0, 0));
		send_req(mk_req(CMD_UNION, 1, 1, 1, 0, 0));
		send_req(mk_req(CMD_READ, NUM_SETS - 1, 0, 0, 0, 1));
	endtask

	// out-of-range set indexes on each checked field
	task automatic test_bad_index();
		send_req(mk_req(CMD_ADD, 7, 0, 0, 5, 0));
		send_req(mk_req(CMD_TEST, NUM_SETS, 0, 0, 0, 0));
		send_req(mk_req(CMD_UNION, 2, 7, 1, 0, 0));
		send_req(mk_req(CMD_INTERSECT, 2, 1, NUM_SETS, 0, 0));
		send_req(mk_req(CMD_READ, 7, 0, 0, 0, 1));
		drain_results();
	endtask

	function automatic int pick_set();
		if ($urandom_range(99) < 88)
			return $urandom_range(NUM_SETS - 1, 0);
		return $urandom_range(7, NUM_SETS);
	endfunction

	function automatic req_t rand_req();
		int   w;
		cmd_t c;
		int   elem;
		w = $urandom_range(99);
		if (w < 5)
			c = CMD_CLEAR;
		else if (w < 35)
			c = CMD_ADD;
		else if (w < 47)
			c = CMD_REMOVE;
		else if (w < 62)
			c = CMD_TEST;
		else if (w < 70)
			c = CMD_UNION;
		else if (w < 78)
			c = CMD_INTERSECT;
		else if (w < 86)
			c = CMD_DIFF;
		else
			c = CMD_READ;
		// a small element pool so tests and removes often hit
		if ($urandom_range(99) < 50)
			elem = $urandom_range(15, 0);
		else
			elem = $urandom_range(127, 0);
		return mk_req(c, pick_set(), pick_set(), pick_set(), elem, $urandom_range(1, 0));
	endfunction

	// result side blocked for a long stretch while requests keep coming
	task automatic test_backpressure();
		src_idle_pct = 0;
		hold_left    = HOLD_LEN;
		repeat (40)
			send_req(rand_req());
		drain_results();
	endtask

	task automatic test_random_mix(input int n);
		repeat (n)
			send_req(rand_req());
		drain_results();
	endtask

	// result-side ready, with an optional long hold-off
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
			end
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_due_q.size() == 0) begin
				$error("result with no request outstanding");
				fail_cnt++;
			end else begin
				want = rsp_due_q.pop_front();
				if (rsp_ch.data.is_member !== want.is_member) begin
					$error("is_member: expected %0d, got %0d", want.is_member,
						rsp_ch.data.is_member);
					fail_cnt++;
				end
				if (rsp_ch.data.data_word !== want.data_word) begin
					$error("data_word: expected %h, got %h", want.data_word,
						rsp_ch.data.data_word);
					fail_cnt++;
				end
				if (rsp_ch.data.set_empty !== want.set_empty) begin
					$error("set_empty: expected %0d, got %0d", want.set_empty,
						rsp_ch.data.set_empty);
					fail_cnt++;
				end
				if (rsp_ch.data.error !== want.error) begin
					$error("error: expected %0d, got %0d", want.error, rsp_ch.data.error);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_MAX) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// test sequence
	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		for (int i = 0; i < NUM_SETS; i++)
			set_mirror[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 14;
		dst_idle_pct = 80;
		test_membership();
		test_set_algebra();
		test_bad_index();
		test_random_mix(380);

		src_idle_pct = 80;
		dst_idle_pct = 14;
		test_random_mix(380);

		src_idle_pct = 0;
		dst_idle_pct = 0;
		test_random_mix(380);
		test_backpressure();

		drain_results();
		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* bitset_register_file_ops_top.f */
sv/bsr_pkg.sv
sv/bsr_req_if.sv
sv/bsr_rsp_if.sv
sv/bsr_ram.sv
sv/bsr_alu.sv
sv/bitset_register_file_ops_top.sv
sv/bsr_checker.sv
sim/tb_top.sv
